@@ rtl/hsl_pkg.sv @@
package hsl_pkg;

    // Hue units: 1/16 degree with 16 fraction bits
    localparam logic [28:0] HUE_SEXT = 29'd62914560;   // 60 degrees
    localparam logic [28:0] HUE_TURN = 29'd377487360;  // 360 degrees

    // Lightness / saturation / channel scale: one = 2^24
    localparam logic [24:0] ONE_FX = 25'h1000000;

    // Divider geometry: 40-bit dividend, 8-bit divisor, 4 quotient bits per stage
    localparam int DIV_W      = 40;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    // Ramp pipeline depth
    localparam int RAMP_STAGES = 6;

    // floor(2^33 / 15), estimate of y / 15 that is low by at most one
    localparam logic [29:0] RECIP15 = 30'd572662306;

    // Configuration register indexes
    typedef enum logic {
        CFG_HUE_SHIFT = 1'b0,
        CFG_SAT_SCALE = 1'b1
    } t_cfg_idx;

    // Original pixel and bypass flag, carried alongside the math
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       ident;
    } t_pix;

    // Sideband that travels next to the dividers
    typedef struct packed {
        t_pix        pix;
        logic        neg;
        logic [28:0] base;
        logic [8:0]  sum;
    } t_side;

    // Per-channel ramp request
    typedef struct packed {
        logic [28:0] t;
        logic [24:0] p;
        logic [24:0] q;
        logic [24:0] diff;
    } t_ramp_in;

endpackage

@@ rtl/hsl_div.sv @@
module hsl_div import hsl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_dvd,
    input  logic [7:0]       i_dsr,
    output logic [DIV_W-1:0] o_quo
);

    typedef struct packed {
        logic [7:0]       rem;
        logic [DIV_W-1:0] dvd;
    } t_div_st;

    // Four restoring steps; quotient bits shift into the dividend word
    function automatic t_div_st div_step(t_div_st st, logic [7:0] dsr);
        t_div_st    res;
        logic [8:0] t;
        res = st;
        for (int k = 0; k < DIV_STEP; k++) begin
            t       = {res.rem, res.dvd[DIV_W-1]};
            res.dvd = {res.dvd[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, dsr}) begin
                t          = t - {1'b0, dsr};
                res.dvd[0] = 1'b1;
            end
            res.rem = t[7:0];
        end
        return res;
    endfunction

    t_div_st    r_st  [DIV_STAGES];
    logic [7:0] r_dsr [DIV_STAGES];
    t_div_st    n_st0;

    assign n_st0 = div_step('{rem: 8'd0, dvd: i_dvd}, i_dsr);

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= n_st0;
            r_dsr[0] <= i_dsr;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_st[k]  <= div_step(r_st[k-1], r_dsr[k-1]);
                r_dsr[k] <= r_dsr[k-1];
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].dvd;

endmodule

@@ rtl/hsl_ramp.sv @@
module hsl_ramp import hsl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_ramp_in i_rin,
    output logic [7:0] o_byte
);

    typedef enum logic [1:0] {
        SEL_RAMP = 2'd0,
        SEL_Q    = 2'd1,
        SEL_P    = 2'd2
    } t_ramp_sel;

    localparam logic [28:0] SEXT3 = 29'(HUE_SEXT * 3);
    localparam logic [28:0] SEXT4 = 29'(HUE_SEXT * 4);

    // Stage 1: classify hue position
    t_ramp_sel   n1_sel;
    logic [25:0] n1_a;
    logic [28:0] n1_dn;

    assign n1_dn = SEXT4 - i_rin.t;

    always_comb begin
        n1_sel = SEL_P;
        n1_a   = i_rin.t[25:0];
        if (i_rin.t < HUE_SEXT) begin
            n1_sel = SEL_RAMP;
        end else if (i_rin.t < SEXT3) begin
            n1_sel = SEL_Q;
        end else if (i_rin.t < SEXT4) begin
            n1_sel = SEL_RAMP;
            n1_a   = n1_dn[25:0];
        end
    end

    t_ramp_sel   r1_sel, r2_sel, r3_sel, r4_sel;
    logic [25:0] r1_a;
    logic [24:0] r1_p, r1_q, r1_diff;
    logic [24:0] r2_p, r2_q, r3_p, r3_q, r4_p, r4_q;
    logic [37:0] r2_hi, r2_lo;
    logic [28:0] r3_y, r4_y;
    logic [25:0] r4_qe;
    logic [24:0] r5_v;

    // Stage 2: partial products of diff * a
    logic [37:0] n2_hi, n2_lo;
    assign n2_hi = 38'(r1_diff) * 38'(r1_a[25:13]);
    assign n2_lo = 38'(r1_diff) * 38'(r1_a[12:0]);

    // Stage 3: combine, divide by 2^22 (the 2^16 fraction and 64 of 960)
    logic [50:0] n3_x;
    assign n3_x = {r2_hi, 13'd0} + 51'(r2_lo);

    // Stage 4: reciprocal estimate of y / 15
    logic [58:0] n4_prod;
    assign n4_prod = 59'(r3_y) * 59'(RECIP15);

    // Stage 5: correct the estimate and pick the channel value
    logic [29:0] n5_m15, n5_rr;
    logic [25:0] n5_qf;
    logic [24:0] n5_v;

    assign n5_m15 = {r4_qe, 4'd0} - 30'(r4_qe);
    assign n5_rr  = 30'(r4_y) - n5_m15;
    assign n5_qf  = (n5_rr >= 30'd15) ? r4_qe + 26'd1 : r4_qe;

    always_comb begin
        case (r4_sel)
            SEL_RAMP: n5_v = r4_p + n5_qf[24:0];
            SEL_Q:    n5_v = r4_q;
            SEL_P:    n5_v = r4_p;
            default:  n5_v = r4_p;
        endcase
    end

    // Stage 6: scale to 8 bits, round half up
    logic [33:0] n6_w;
    logic [7:0]  n6_b;
    assign n6_w = {1'b0, r5_v, 8'd0} - 34'(r5_v) + 34'h0800000;
    assign n6_b = (n6_w[33:24] > 10'd255) ? 8'd255 : n6_w[31:24];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sel  <= n1_sel;
            r1_a    <= n1_a;
            r1_p    <= i_rin.p;
            r1_q    <= i_rin.q;
            r1_diff <= i_rin.diff;

            r2_sel  <= r1_sel;
            r2_p    <= r1_p;
            r2_q    <= r1_q;
            r2_hi   <= n2_hi;
            r2_lo   <= n2_lo;

            r3_sel  <= r2_sel;
            r3_p    <= r2_p;
            r3_q    <= r2_q;
            r3_y    <= n3_x[50:22];

            r4_sel  <= r3_sel;
            r4_p    <= r3_p;
            r4_q    <= r3_q;
            r4_y    <= r3_y;
            r4_qe   <= n4_prod[58:33];

            r5_v    <= n5_v;

            o_byte  <= n6_b;
        end
    end

endmodule

@@ rtl/hsl_hue_rotate_sat_scale.sv @@
// HSL hue rotation and saturation scaling, one RGB888 pixel per clock.
// Each pixel is taken to HSL, its hue is rotated by hue_shift (signed,
// 1/16 degree, wrapping modulo 360) and its saturation multiplied by
// sat_scale (unsigned Q8.8, clamped at one), then taken back to RGB with
// round-half-up to 8 bits. Grays, and any pixel while hue_shift is zero and
// sat_scale is 256, pass unchanged. A request is accepted on every clock
// while the output side is not stalled; two 10-stage dividers (hue sector
// offset and saturation) and a 6-stage per-channel ramp set the pipeline
// depth. When the output is stalled the whole pipeline holds and o_stall is
// raised. Write registers only while the pipeline is empty.
module hsl_hue_rotate_sat_scale import hsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // pixel in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    // pixel out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    localparam logic [28:0]        SEXT2   = 29'(HUE_SEXT * 2);
    localparam logic [28:0]        SEXT4   = 29'(HUE_SEXT * 4);
    localparam logic signed [31:0] TURN_S  = 32'sd377487360;
    localparam logic signed [31:0] TURN2_S = 32'sd754974720;

    // Configuration registers
    logic signed [13:0] r_hue_shift;
    logic [15:0]        r_sat_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_shift <= '0;
            r_sat_scale <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HUE_SHIFT: r_hue_shift <= i_cfg_data[13:0];
                CFG_SAT_SCALE: r_sat_scale <= i_cfg_data;
                default:       r_sat_scale <= r_sat_scale;
            endcase
        end
    end

    // Global advance: everything moves unless the output holds a stalled request
    logic en;
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Stage 0: input capture
    logic       r_s0_valid;
    logic [7:0] r_s0_red, r_s0_green, r_s0_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_red   <= i_red_in;
            r_s0_green <= i_green_in;
            r_s0_blue  <= i_blue_in;
        end
    end

    // Stage A: max/min, hue sector, divider operands
    logic [7:0]       a_mx, a_mn, a_d, a_num;
    logic [8:0]       a_sum, a_den;
    logic             a_neg;
    logic [28:0]      a_base;
    logic [17:0]      a_num960;
    logic [23:0]      a_dsat;
    t_side            a_side;
    logic [7:0]       rr, gg, bb;

    assign rr = r_s0_red;
    assign gg = r_s0_green;
    assign bb = r_s0_blue;

    always_comb begin
        a_mx = (rr > gg) ? ((rr > bb) ? rr : bb) : ((gg > bb) ? gg : bb);
        a_mn = (rr < gg) ? ((rr < bb) ? rr : bb) : ((gg < bb) ? gg : bb);
        a_d  = a_mx - a_mn;
        if (rr >= gg && rr >= bb) begin
            if (gg >= bb) begin
                a_base = '0;       a_neg = 1'b0; a_num = gg - bb;
            end else begin
                a_base = HUE_TURN; a_neg = 1'b1; a_num = bb - gg;
            end
        end else if (gg >= bb) begin
            a_base = SEXT2;
            if (bb >= rr) begin
                a_neg = 1'b0; a_num = bb - rr;
            end else begin
                a_neg = 1'b1; a_num = rr - bb;
            end
        end else begin
            a_base = SEXT4;
            if (rr >= gg) begin
                a_neg = 1'b0; a_num = rr - gg;
            end else begin
                a_neg = 1'b1; a_num = gg - rr;
            end
        end
    end

    assign a_sum    = {1'b0, a_mx} + {1'b0, a_mn};
    assign a_den    = (a_sum <= 9'd255) ? a_sum : 9'd510 - a_sum;
    assign a_num960 = 18'(a_num) * 18'd960;
    assign a_dsat   = 24'(a_d) * 24'(r_sat_scale);

    assign a_side.pix.red   = rr;
    assign a_side.pix.green = gg;
    assign a_side.pix.blue  = bb;
    assign a_side.pix.ident = (r_hue_shift == 14'sd0 && r_sat_scale == 16'd256) ||
                              (a_d == 8'd0);
    assign a_side.neg       = a_neg;
    assign a_side.base      = a_base;
    assign a_side.sum       = a_sum;

    // Stage 1: divider operands
    logic             r_s1_valid;
    t_side            r_s1_side;
    logic [DIV_W-1:0] r_s1_hdvd, r_s1_sdvd;
    logic [7:0]       r_s1_d, r_s1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= a_side;
            r_s1_hdvd <= {6'd0, a_num960, 16'd0};
            r_s1_sdvd <= {a_dsat, 16'd0};
            r_s1_d    <= a_d;
            r_s1_den  <= a_den[7:0];
        end
    end

    // Hue offset within sector and raw saturation
    logic [DIV_W-1:0] hue_off, sat_quo;

    hsl_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd (r_s1_hdvd),
        .i_dsr (r_s1_d),
        .o_quo (hue_off)
    );

    hsl_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd (r_s1_sdvd),
        .i_dsr (r_s1_den),
        .o_quo (sat_quo)
    );

    // Sideband delay matching the dividers
    t_side r_dv_side  [DIV_STAGES];
    logic  r_dv_valid [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_dv_valid[k] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r_s1_valid;
            for (int k = 1; k < DIV_STAGES; k++) r_dv_valid[k] <= r_dv_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_s1_side;
            for (int k = 1; k < DIV_STAGES; k++) r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // Stage E: rotated hue, clamped saturation, lightness
    t_side              e_side;
    logic signed [31:0] e_h0, e_v, e_hw;
    logic [15:0]        e_y;
    logic [24:0]        e_prod;
    logic [8:0]         e_qe, e_qf;
    logic [16:0]        e_chk, e_rr;
    logic [24:0]        e_l, e_s;

    assign e_side = r_dv_side[DIV_STAGES-1];

    always_comb begin
        if (e_side.neg) begin
            e_h0 = signed'({3'd0, e_side.base}) - signed'({6'd0, hue_off[25:0]});
        end else begin
            e_h0 = signed'({3'd0, e_side.base}) + signed'({6'd0, hue_off[25:0]});
        end
        e_v = e_h0 + signed'({{2{r_hue_shift[13]}}, r_hue_shift, 16'd0});
        if (e_v < -TURN_S) begin
            e_hw = e_v + TURN2_S;
        end else if (e_v < 32'sd0) begin
            e_hw = e_v + TURN_S;
        end else if (e_v >= TURN2_S) begin
            e_hw = e_v - TURN2_S;
        end else if (e_v >= TURN_S) begin
            e_hw = e_v - TURN_S;
        end else begin
            e_hw = e_v;
        end
    end

    // l = sum * 2^23 / 255 = sum * 32896 + sum * 128 / 255
    assign e_y    = {e_side.sum, 7'd0};
    assign e_prod = 25'(e_y) * 25'd257;
    assign e_qe   = e_prod[24:16];
    assign e_chk  = {e_qe, 8'd0} - 17'(e_qe);
    assign e_rr   = 17'(e_y) - e_chk;
    assign e_qf   = (e_rr >= 17'd255) ? e_qe + 9'd1 : e_qe;
    assign e_l    = 25'(e_side.sum) * 25'd32896 + 25'(e_qf);
    assign e_s    = (sat_quo > DIV_W'(ONE_FX)) ? ONE_FX : sat_quo[24:0];

    logic        r_s2_valid;
    t_pix        r_s2_pix;
    logic [28:0] r_s2_h;
    logic [24:0] r_s2_l, r_s2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_dv_valid[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pix <= e_side.pix;
            r_s2_h   <= e_hw[28:0];
            r_s2_l   <= e_l;
            r_s2_s   <= e_s;
        end
    end

    // Stage F: l * s
    logic        r_s3_valid;
    t_pix        r_s3_pix;
    logic [28:0] r_s3_h;
    logic [24:0] r_s3_l, r_s3_s;
    logic [49:0] r_s3_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_pix <= r_s2_pix;
            r_s3_h   <= r_s2_h;
            r_s3_l   <= r_s2_l;
            r_s3_s   <= r_s2_s;
            r_s3_m   <= 50'(r_s2_l) * 50'(r_s2_s);
        end
    end

    // Stage G: q, p, per-channel hue positions
    logic [25:0]        g_ms, g_2l;
    logic [26:0]        g_qw;
    logic [24:0]        g_q, g_p, g_diff;
    logic [29:0]        g_tr;
    logic signed [30:0] g_tb;
    logic [28:0]        g_tr_w, g_tb_w;

    assign g_ms = r_s3_m[49:24];

    always_comb begin
        if (r_s3_l < 25'h0800000) begin
            g_qw = 27'(r_s3_l) + 27'(g_ms);
        end else begin
            g_qw = 27'(r_s3_l) + 27'(r_s3_s) - 27'(g_ms);
        end
    end

    assign g_q    = g_qw[24:0];
    assign g_2l   = {r_s3_l, 1'b0};
    assign g_p    = (g_2l > 26'(g_q)) ? 25'(g_2l - 26'(g_q)) : 25'd0;
    assign g_diff = (g_q > g_p) ? g_q - g_p : 25'd0;

    assign g_tr   = 30'(r_s3_h) + 30'(SEXT2);
    assign g_tr_w = (g_tr >= 30'(HUE_TURN)) ? 29'(g_tr - 30'(HUE_TURN)) : g_tr[28:0];
    assign g_tb   = signed'({2'd0, r_s3_h}) - signed'({2'd0, SEXT2});
    assign g_tb_w = (g_tb < 31'sd0) ? 29'(g_tb + signed'({2'd0, HUE_TURN})) : g_tb[28:0];

    logic     r_s4_valid;
    t_pix     r_s4_pix;
    t_ramp_in r_s4_red, r_s4_green, r_s4_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_pix   <= r_s3_pix;
            r_s4_red   <= '{t: g_tr_w, p: g_p, q: g_q, diff: g_diff};
            r_s4_green <= '{t: r_s3_h, p: g_p, q: g_q, diff: g_diff};
            r_s4_blue  <= '{t: g_tb_w, p: g_p, q: g_q, diff: g_diff};
        end
    end

    // Per-channel ramps
    logic [7:0] rp_red, rp_green, rp_blue;

    hsl_ramp u_ramp_red (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rin  (r_s4_red),
        .o_byte (rp_red)
    );

    hsl_ramp u_ramp_green (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rin  (r_s4_green),
        .o_byte (rp_green)
    );

    hsl_ramp u_ramp_blue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rin  (r_s4_blue),
        .o_byte (rp_blue)
    );

    // Sideband delay matching the ramps
    t_pix r_rp_pix   [RAMP_STAGES];
    logic r_rp_valid [RAMP_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RAMP_STAGES; k++) r_rp_valid[k] <= 1'b0;
        end else if (en) begin
            r_rp_valid[0] <= r_s4_valid;
            for (int k = 1; k < RAMP_STAGES; k++) r_rp_valid[k] <= r_rp_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rp_pix[0] <= r_s4_pix;
            for (int k = 1; k < RAMP_STAGES; k++) r_rp_pix[k] <= r_rp_pix[k-1];
        end
    end

    // Output register with bypass for grays and identity settings
    t_pix       o_pix;
    logic [7:0] r_out_red, r_out_green, r_out_blue;

    assign o_pix = r_rp_pix[RAMP_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_rp_valid[RAMP_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_red   <= o_pix.ident ? o_pix.red   : rp_red;
            r_out_green <= o_pix.ident ? o_pix.green : rp_green;
            r_out_blue  <= o_pix.ident ? o_pix.blue  : rp_blue;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out_red;
    assign o_green_out = r_out_green;
    assign o_blue_out  = r_out_blue;

endmodule

@@ tb/hsl_hue_rotate_sat_scale_chk.sv @@
module hsl_hue_rotate_sat_scale_chk import hsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_red_out,
    input  logic [7:0]  i_green_out,
    input  logic [7:0]  i_blue_out,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SEXT  = 64'd62914560;
    localparam longint TURN  = SEXT * 6;
    localparam longint ONE   = 64'd1 << 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic [13:0] hue_reg;
    logic [15:0] sat_reg;
    t_rgb        pixel_q[$];

    function automatic longint wrap_turn(longint t);
        return (t + TURN * 2) % TURN;
    endfunction

    function automatic longint chan_level(longint p, longint q, longint t);
        longint diff;
        diff = (q > p) ? q - p : 0;
        if (t < SEXT) return p + (diff * 6 * t) / TURN;
        if (t < SEXT * 3) return q;
        if (t < SEXT * 4) return p + (diff * 6 * (SEXT * 4 - t)) / TURN;
        return p;
    endfunction

    function automatic logic [7:0] level_byte(longint v);
        longint x;
        x = (v * 255 + (ONE >> 1)) >> 24;
        return (x > 255) ? 8'd255 : x[7:0];
    endfunction

    // expected output pixel for the current settings
    function automatic t_rgb rotate_pixel(t_rgb px);
        longint r, g, b, mx, mn, d, sum, den, l, s, q, p, h, sh;
        t_rgb o;
        r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
        o = px;
        if (hue_reg == 0 && sat_reg == 256) return o;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d = mx - mn;
        if (d == 0) return o;
        if (r >= g && r >= b) begin
            h = (g >= b) ? (SEXT * (g - b)) / d : TURN - (SEXT * (b - g)) / d;
        end else if (g >= b) begin
            h = (b >= r) ? SEXT * 2 + (SEXT * (b - r)) / d : SEXT * 2 - (SEXT * (r - b)) / d;
        end else begin
            h = (r >= g) ? SEXT * 4 + (SEXT * (r - g)) / d : SEXT * 4 - (SEXT * (g - r)) / d;
        end
        sh = longint'($signed(hue_reg));
        h = wrap_turn(h + sh * 65536);
        sum = mx + mn;
        den = (sum <= 255) ? sum : 510 - sum;
        l = (sum << 24) / 510;
        s = (d * longint'(sat_reg) * ONE) / (den * 256);
        if (s > ONE) s = ONE;
        if (l < (ONE >> 1)) q = (l * (ONE + s)) >> 24;
        else q = l + s - ((l * s) >> 24);
        p = (2 * l > q) ? 2 * l - q : 0;
        o.red   = level_byte(chan_level(p, q, wrap_turn(h + SEXT * 2)));
        o.green = level_byte(chan_level(p, q, h));
        o.blue  = level_byte(chan_level(p, q, wrap_turn(h - SEXT * 2)));
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            hue_reg  <= 14'd0;
            sat_reg  <= 16'd256;
            o_errors <= 0;
            pixel_q.delete();
        end else begin
            // requests in: predict with settings as they stand
            if (i_valid && !i_in_stall)
                pixel_q.push_back(rotate_pixel('{i_red_in, i_green_in, i_blue_in}));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HUE_SHIFT) hue_reg <= i_cfg_data[13:0];
                else sat_reg <= i_cfg_data;
            end
            // results out
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected pixel", i_red_out, -1);
                end else begin
                    want = pixel_q.pop_front();
                    if (i_red_out != want.red) report_mismatch("red", i_red_out, want.red);
                    if (i_green_out != want.green)
                        report_mismatch("green", i_green_out, want.green);
                    if (i_blue_out != want.blue) report_mismatch("blue", i_blue_out, want.blue);
                end
            end
        end
    end
endmodule

@@ tb/hsl_hue_rotate_sat_scale_tb.sv @@
module hsl_hue_rotate_sat_scale_tb import hsl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red_out, o_green_out, o_blue_out;
    int          errors, pending;
    int          idle_pct = 26, stall_pct = 84;
    int          quiet = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hsl_hue_rotate_sat_scale DUT (.*);

    hsl_hue_rotate_sat_scale_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall), .i_red_in, .i_green_in, .i_blue_in,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .o_errors(errors), .o_pending(pending)
    );

    // output-side backpressure
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("hsl_hue_rotate_sat_scale regression: fail");
            $finish;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_in <= r; i_green_in <= g; i_blue_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(int n);
        logic [7:0] r, g, b;
        repeat (n) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            // some grays and ties
            case ($urandom_range(9))
                0: begin g = r; b = r; end
                1: g = r;
                2: b = g;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task automatic directed_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd100, 8'd30, 8'd70);
    endtask

    // settings: hue, sat
    logic [15:0] hue_set[10] = '{16'h0000, 16'h1680, 16'h2980, 16'h1FFF, 16'h2000,
                                 16'h00F0, 16'h3F10, 16'h0001, 16'h0000, 16'h3000};
    logic [15:0] sat_set[10] = '{16'h0100, 16'h0100, 16'h0000, 16'hFFFF, 16'h0080,
                                 16'h0100, 16'h0200, 16'h0101, 16'h00FF, 16'h0180};

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset settings are the identity
        directed_pixels();
        drain_pipe();
        for (int k = 0; k < 10; k++) begin
            if (k < 3) begin idle_pct = 26; stall_pct = 84; end
            else if (k < 6) begin idle_pct = 84; stall_pct = 26; end
            else begin idle_pct = 0; stall_pct = 0; end
            write_reg(CFG_HUE_SHIFT, hue_set[k]);
            write_reg(CFG_SAT_SCALE, sat_set[k]);
            if (k < 3) directed_pixels();
            random_pixels(k == 9 ? 80 : 120);
            drain_pipe();
        end
        // random settings, four short phases
        repeat (4) begin
            write_reg(CFG_HUE_SHIFT, 16'($urandom));
            write_reg(CFG_SAT_SCALE, 16'($urandom_range(1024)));
            random_pixels(40);
            drain_pipe();
        end
        if (errors == 0 && pending == 0) begin
            $display("hsl_hue_rotate_sat_scale regression: pass");
        end else begin
            $display("hsl_hue_rotate_sat_scale regression: fail");
        end
        $finish;
    end
endmodule
